// ===== rtl/core/lse_pkg.sv =====
// Shared types and constants for the LSB stego extractor.
`default_nettype none
package lse_pkg;

    localparam int LEN_HEADER_BITS   = 32;
    localparam int DEPTH_HEADER_BITS = 8;
    localparam int HEADER_PIXELS     = 40;
    localparam int MAX_DEPTH         = 6;

    localparam int CNT_W   = 27;
    localparam int LEN_W   = 32;
    localparam int CAP_W   = 30;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [0:0] CFG_CHANNEL_COUNT = 1'd0;
    localparam logic [0:0] CFG_IMAGE_BYTES   = 1'd1;

    typedef enum logic [1:0] {
        PH_LENGTH,
        PH_DEPTH,
        PH_MESSAGE,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        OC_BYTE    = 2'd0,
        OC_INVALID = 2'd1,
        OC_EMPTY   = 2'd2
    } t_outcome;

    // One result word produced by one input byte.
    typedef struct packed {
        logic [7:0] byte0;
        t_outcome   oc0;
        logic       last0;
    } t_rec;

endpackage
`default_nettype wire

// ===== rtl/core/lse_front.sv =====
// Front end: header parsing, depth check and bit extraction per image byte.
`default_nettype none
module lse_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_accept,
    input  wire logic [7:0]                i_image_byte,
    input  wire logic                      i_frame_start,
    input  wire logic [2:0]                i_channel_count,
    input  wire logic [lse_pkg::CNT_W-1:0] i_image_bytes,
    output lse_pkg::t_rec                  o_rec,
    output logic                           o_rec_valid
);
    import lse_pkg::*;

    t_phase            r_phase, n_phase, cur_phase;
    logic [CNT_W-1:0]  r_cnt, n_cnt, cur_cnt;
    logic [LEN_W-1:0]  r_len, n_len, cur_len;
    logic [7:0]        r_depth, n_depth, cur_depth;
    logic [7:0]        r_asm, n_asm, cur_asm;
    logic [2:0]        r_pos, n_pos, cur_pos;
    logic              r_held_valid, n_held_valid;
    logic [7:0]        r_held_byte, n_held_byte;

    logic [2:0]        cc;
    logic [CNT_W-1:0]  depth_start, depth_end, msg_start;
    logic [7:0]        new_depth;
    logic [CAP_W-1:0]  cap;
    logic              hdr_ok;
    logic              hdr_end, in_msg, last_chunk;
    logic [2:0]        d, t, rest;
    logic [7:0]        new_bits;
    logic [13:0]       combined;
    logic [3:0]        total;
    logic [7:0]        full_byte, rest_bits;

    always_comb begin
        cur_phase = i_frame_start ? PH_LENGTH : r_phase;
        cur_cnt   = i_frame_start ? '0 : r_cnt;
        cur_len   = i_frame_start ? '0 : r_len;
        cur_depth = i_frame_start ? '0 : r_depth;
        cur_asm   = i_frame_start ? '0 : r_asm;
        cur_pos   = i_frame_start ? '0 : r_pos;
    end

    always_comb begin
        cc          = (i_channel_count == 3'd0) ? 3'd1 : i_channel_count;
        depth_start = CNT_W'(LEN_HEADER_BITS) * CNT_W'(cc);
        depth_end   = depth_start + CNT_W'(DEPTH_HEADER_BITS - 1);
        msg_start   = CNT_W'(HEADER_PIXELS) * CNT_W'(cc);
        new_depth   = {cur_depth[6:0], i_image_byte[0]};
        cap         = CAP_W'(i_image_bytes) * CAP_W'(new_depth[2:0]);
        hdr_ok      = (new_depth >= 8'd1) && (new_depth <= 8'(MAX_DEPTH))
                      && (cur_len < LEN_W'(cap));
        hdr_end     = (cur_cnt == depth_end);
        in_msg      = (cur_cnt >= msg_start);
        d           = cur_depth[2:0];
        last_chunk  = (cur_len <= LEN_W'(d));
        t           = last_chunk ? cur_len[2:0] : d;
        new_bits    = (i_image_byte >> (d - t)) & 8'((9'd1 << t) - 9'd1);
        combined    = ({6'd0, cur_asm} << t) | {6'd0, new_bits};
        total       = {1'b0, cur_pos} + {1'b0, t};
        rest        = 3'(total - 4'd8);
        full_byte   = 8'(combined >> (total - 4'd8));
        rest_bits   = combined[7:0] & 8'((9'd1 << rest) - 9'd1);
    end

    // phase sequencing
    always_comb begin
        n_phase = cur_phase;
        unique case (cur_phase)
            PH_LENGTH: begin
                if (cur_cnt >= CNT_W'(LEN_HEADER_BITS - 1)) n_phase = PH_DEPTH;
            end
            PH_DEPTH: begin
                if (cur_cnt >= depth_start && hdr_end) begin
                    if (!hdr_ok || cur_len == '0) n_phase = PH_DONE;
                    else                          n_phase = PH_MESSAGE;
                end
            end
            PH_MESSAGE: begin
                if (in_msg && last_chunk) n_phase = PH_DONE;
            end
            PH_DONE: n_phase = PH_DONE;
            default: n_phase = PH_DONE;
        endcase
    end

    // datapath and result words
    always_comb begin
        n_cnt        = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
        n_len        = cur_len;
        n_depth      = cur_depth;
        n_asm        = cur_asm;
        n_pos        = cur_pos;
        n_held_valid = 1'b0;
        n_held_byte  = r_held_byte;
        o_rec_valid  = 1'b0;
        o_rec        = '{byte0: 8'd0, oc0: OC_BYTE, last0: 1'b0};
        unique case (cur_phase)
            PH_LENGTH: n_len = {cur_len[LEN_W-2:0], i_image_byte[0]};
            PH_DEPTH: begin
                if (cur_cnt >= depth_start && cur_cnt <= depth_end) begin
                    n_depth = new_depth;
                    if (hdr_end) begin
                        if (!hdr_ok) begin
                            o_rec_valid = 1'b1;
                            o_rec.oc0   = OC_INVALID;
                            o_rec.last0 = 1'b1;
                        end else if (cur_len == '0) begin
                            o_rec_valid = 1'b1;
                            o_rec.oc0   = OC_EMPTY;
                            o_rec.last0 = 1'b1;
                        end
                    end
                end
            end
            PH_MESSAGE: begin
                if (in_msg) begin
                    n_len = cur_len - LEN_W'(t);
                    if (total >= 4'd8) begin
                        o_rec_valid = 1'b1;
                        o_rec.byte0 = full_byte;
                        o_rec.last0 = last_chunk && (rest == 3'd0);
                        n_asm       = rest_bits;
                        n_pos       = rest;
                        if (last_chunk && rest != 3'd0) begin
                            n_held_valid = 1'b1;
                            n_held_byte  = rest_bits;
                        end
                    end else begin
                        n_asm = combined[7:0];
                        n_pos = total[2:0];
                        if (last_chunk) begin
                            o_rec_valid = 1'b1;
                            o_rec.byte0 = combined[7:0];
                            o_rec.last0 = 1'b1;
                        end
                    end
                end
            end
            PH_DONE: ;
            default: ;
        endcase
        // final partial byte left from the previous input goes out first
        if (r_held_valid) begin
            o_rec_valid = 1'b1;
            o_rec       = '{byte0: r_held_byte, oc0: OC_BYTE, last0: 1'b1};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LENGTH;
            r_cnt        <= '0;
            r_len        <= '0;
            r_depth      <= '0;
            r_asm        <= '0;
            r_pos        <= '0;
            r_held_valid <= 1'b0;
            r_held_byte  <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_cnt        <= n_cnt;
            r_len        <= n_len;
            r_depth      <= n_depth;
            r_asm        <= n_asm;
            r_pos        <= n_pos;
            r_held_valid <= n_held_valid;
            r_held_byte  <= n_held_byte;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lse_fifo.sv =====
// Short queue of result records between front and back.
`default_nettype none
module lse_fifo (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_wr,
    input  wire lse_pkg::t_rec i_rec,
    output logic        o_full,
    input  wire logic   i_rd,
    output lse_pkg::t_rec o_rec,
    output logic        o_empty
);
    import lse_pkg::*;

    t_rec              r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wp, r_rp;
    logic [Q_AW:0]     r_count;
    logic              wr_en, rd_en;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_rec   = r_mem[r_rp];
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[r_wp] <= i_rec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (wr_en) r_wp <= r_wp + 1'b1;
            if (rd_en) r_rp <= r_rp + 1'b1;
            if (wr_en && !rd_en)      r_count <= r_count + 1'b1;
            else if (rd_en && !wr_en) r_count <= r_count - 1'b1;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lse_back.sv =====
// Back end: holds the output word and refills it from the queue.
`default_nettype none
module lse_back (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire lse_pkg::t_rec i_rec,
    input  wire logic   i_q_empty,
    output logic        o_q_rd,
    input  wire logic   pop,
    output logic        empty,
    output logic [7:0]  o_message_byte,
    output logic [1:0]  o_outcome,
    output logic        o_last_byte
);
    import lse_pkg::*;

    logic       r_out_valid;
    logic [7:0] r_byte;
    t_outcome   r_oc;
    logic       r_last;
    logic       load;

    assign empty          = !r_out_valid;
    assign o_message_byte = r_byte;
    assign o_outcome      = r_oc;
    assign o_last_byte    = r_last;
    assign load           = !r_out_valid || pop;
    assign o_q_rd         = load && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && !i_q_empty) begin
            r_byte <= i_rec.byte0;
            r_oc   <= i_rec.oc0;
            r_last <= i_rec.last0;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/lsb_stego_extractor.sv =====
// Top level of the LSB stego extractor: config registers, front, queue, back.
//
// Takes one image channel byte per cycle while full is low; frame_start
// restarts extraction on that byte. Header parsing and bit extraction are
// done combinationally in the front end, which writes one record per
// result-producing byte into a four-entry queue. A byte that both completes
// a full message byte and ends the message yields the full byte at once;
// the final partial byte, flagged last, is held in the front end and issued
// when the next byte is taken, even one that starts a new frame. The back
// end presents words one per cycle, while pop is high, on a registered
// output. A result enters the queue when its byte is taken and moves to
// the output when that is free or popped; full rises when the queue fills.
`default_nettype none
module lsb_stego_extractor (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cfg_we,
    input  wire logic [0:0]                i_cfg_idx,
    input  wire logic [lse_pkg::CNT_W-1:0] i_cfg_data,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [7:0]                i_image_byte,
    input  wire logic                      i_frame_start,
    output logic                           empty,
    input  wire logic                      pop,
    output logic [7:0]                     o_message_byte,
    output logic [1:0]                     o_outcome,
    output logic                           o_last_byte
);
    import lse_pkg::*;

    logic [2:0]       r_channel_count;
    logic [CNT_W-1:0] r_image_bytes;
    logic             accept;
    t_rec             f_rec, q_rec;
    logic             f_rec_valid;
    logic             q_empty, q_rd;

    assign accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_channel_count <= 3'd3;
            r_image_bytes   <= CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_CHANNEL_COUNT: r_channel_count <= i_cfg_data[2:0];
                CFG_IMAGE_BYTES:   r_image_bytes   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lse_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_image_byte    (i_image_byte),
        .i_frame_start   (i_frame_start),
        .i_channel_count (r_channel_count),
        .i_image_bytes   (r_image_bytes),
        .o_rec           (f_rec),
        .o_rec_valid     (f_rec_valid)
    );

    lse_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept && f_rec_valid),
        .i_rec   (f_rec),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_rec   (q_rec),
        .o_empty (q_empty)
    );

    lse_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec          (q_rec),
        .i_q_empty      (q_empty),
        .o_q_rd         (q_rd),
        .pop            (pop),
        .empty          (empty),
        .o_message_byte (o_message_byte),
        .o_outcome      (o_outcome),
        .o_last_byte    (o_last_byte)
    );

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for lsb_stego_extractor: header/message frames against a local predictor.
`default_nettype none
module tb_top;
    import lse_pkg::*;

    typedef struct packed {
        logic       fs;
        logic [7:0] data;
    } t_image_item;

    typedef struct packed {
        logic [7:0] data;
        t_outcome   oc;
        logic       last;
    } t_message_word;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [0:0]        i_cfg_idx = CFG_CHANNEL_COUNT;
    logic [CNT_W-1:0]  i_cfg_data = '0;
    logic              push = 1'b0;
    logic              full;
    logic [7:0]        i_image_byte = 8'h00;
    logic              i_frame_start = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic [7:0]        o_message_byte;
    logic [1:0]        o_outcome;
    logic              o_last_byte;

    lsb_stego_extractor u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .push           (push),
        .full           (full),
        .i_image_byte   (i_image_byte),
        .i_frame_start  (i_frame_start),
        .empty          (empty),
        .pop            (pop),
        .o_message_byte (o_message_byte),
        .o_outcome      (o_outcome),
        .o_last_byte    (o_last_byte)
    );

    t_image_item   image_feed[$];
    t_message_word expected_words[$];

    // extraction state
    logic [2:0]       cfg_channels = 3'd3;
    logic [CNT_W-1:0] cfg_image_bytes = 27'd1;
    logic [CNT_W-1:0] byte_count = '0;
    logic [31:0]      msg_bits = '0;
    logic [7:0]       depth = '0;
    logic [31:0]      bits_got = '0;
    logic [7:0]       assembly = '0;
    t_phase           stage = PH_LENGTH;
    bit               held_valid = 1'b0;
    logic [7:0]       held_byte = '0;

    bit fed = 1'b0;
    bit hold;
    int feed_idle = 0;
    int pop_stall = 0;
    int errors = 0;
    int words_predicted = 0;
    int words_checked = 0;
    int bytes_taken = 0;
    int frame_items = 0;
    int settings_used = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void add_word(logic [7:0] data, t_outcome oc, logic last);
        t_message_word w;
        w.data = data;
        w.oc   = oc;
        w.last = last;
        expected_words.push_back(w);
        words_predicted++;
    endfunction

    function automatic void extract_byte(logic [7:0] b, logic fs);
        logic [31:0] n;
        logic [31:0] cc;
        logic [31:0] dstart;
        logic [31:0] mstart;
        logic [63:0] cap;
        logic        fin;
        bit          got;
        got = 1'b0;
        // a partial last byte left by the previous byte comes out first
        if (held_valid) begin
            add_word(held_byte, OC_BYTE, 1'b1);
            held_valid = 1'b0;
            got        = 1'b1;
        end
        if (fs) begin
            byte_count = '0;
            msg_bits   = '0;
            depth      = '0;
            bits_got   = '0;
            assembly   = '0;
            stage      = PH_LENGTH;
        end
        n = {5'd0, byte_count};
        if (byte_count != CNT_MAX) byte_count++;
        cc     = (cfg_channels == 3'd0) ? 32'd1 : {29'd0, cfg_channels};
        dstart = LEN_HEADER_BITS * cc;
        mstart = HEADER_PIXELS * cc;
        case (stage)
            PH_LENGTH: begin
                msg_bits = {msg_bits[30:0], b[0]};
                if (n + 1 >= LEN_HEADER_BITS) stage = PH_DEPTH;
            end
            PH_DEPTH: begin
                if (n >= dstart && n < dstart + DEPTH_HEADER_BITS) begin
                    depth = {depth[6:0], b[0]};
                    if (n == dstart + DEPTH_HEADER_BITS - 1) begin
                        cap = 64'(cfg_image_bytes) * 64'(depth);
                        if (!(64'(msg_bits) < cap && depth >= 1 && depth <= MAX_DEPTH)) begin
                            if (!got) add_word(8'h00, OC_INVALID, 1'b1);
                            got   = 1'b1;
                            stage = PH_DONE;
                        end else if (msg_bits == 0) begin
                            if (!got) add_word(8'h00, OC_EMPTY, 1'b1);
                            got   = 1'b1;
                            stage = PH_DONE;
                        end else begin
                            stage = PH_MESSAGE;
                        end
                    end
                end
            end
            PH_MESSAGE: begin
                if (n >= mstart) begin
                    for (int k = depth; k > 0; k--) begin
                        if (bits_got >= msg_bits) break;
                        assembly = {assembly[6:0], b[k-1]};
                        bits_got++;
                        fin = (bits_got == msg_bits);
                        if (bits_got[2:0] == 3'd0 || fin) begin
                            if (!got) begin
                                add_word(assembly, OC_BYTE, fin);
                                got = 1'b1;
                            end else begin
                                held_byte  = assembly;
                                held_valid = 1'b1;
                            end
                            assembly = '0;
                        end
                        if (fin) begin
                            stage = PH_DONE;
                            break;
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // predict on accepted bytes, check popped words
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_channels    = 3'd3;
            cfg_image_bytes = 27'd1;
            byte_count = '0;
            msg_bits   = '0;
            depth      = '0;
            bits_got   = '0;
            assembly   = '0;
            stage      = PH_LENGTH;
            held_valid = 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_CHANNEL_COUNT: cfg_channels = i_cfg_data[2:0];
                    CFG_IMAGE_BYTES:   cfg_image_bytes = i_cfg_data;
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                t_message_word want;
                if (expected_words.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected word: byte %02h outcome %0d last %0b",
                                 o_message_byte, o_outcome, o_last_byte);
                end else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (o_message_byte !== want.data || o_outcome !== want.oc ||
                        o_last_byte !== want.last) begin
                        errors++;
                        if (errors <= 10)
                            $display({"mismatch: expected byte %02h outcome %0d last %0b,",
                                      " got byte %02h outcome %0d last %0b"},
                                     want.data, want.oc, want.last,
                                     o_message_byte, o_outcome, o_last_byte);
                    end
                end
            end
            if (push && !full) begin
                extract_byte(i_image_byte, i_frame_start);
                bytes_taken++;
                fed = 1'b1;
            end
        end
    end

    always @(negedge i_clk) begin
        hold = push && !fed;
        if (fed) begin
            void'(image_feed.pop_front());
            fed = 1'b0;
        end
        if (image_feed.size() != 0 && (hold || $urandom_range(99) >= feed_idle)) begin
            push          <= 1'b1;
            i_image_byte  <= image_feed[0].data;
            i_frame_start <= image_feed[0].fs;
        end else begin
            push <= 1'b0;
        end
        pop <= ($urandom_range(99) >= pop_stall);
    end

    task automatic queue_frame(logic [31:0] len, logic [7:0] dep, int msg_n, bit mark,
                               bit pattern, int keep);
        int cc;
        int total;
        t_image_item it;
        cc    = (cfg_channels == 3'd0) ? 1 : int'(cfg_channels);
        total = HEADER_PIXELS * cc + msg_n;
        if (keep >= 0 && keep < total) total = keep;
        for (int n = 0; n < total; n++) begin
            it.data = 8'($urandom);
            it.fs   = (n == 0) && mark;
            if (n < LEN_HEADER_BITS)
                it.data[0] = len[LEN_HEADER_BITS-1-n];
            else if (n >= LEN_HEADER_BITS * cc && n < LEN_HEADER_BITS * cc + DEPTH_HEADER_BITS)
                it.data[0] = dep[DEPTH_HEADER_BITS-1-(n-LEN_HEADER_BITS*cc)];
            else if (pattern && n >= HEADER_PIXELS * cc)
                it.data = n[0] ? 8'h00 : 8'hFF;
            image_feed.push_back(it);
        end
        frame_items += total;
    endtask

    task automatic queue_random_frame();
        int          kind;
        int          cc;
        int          need;
        int          msg_n;
        bit          mark;
        logic [31:0] len;
        logic [7:0]  dep;
        logic [63:0] cap;
        t_image_item it;
        kind = $urandom_range(99);
        mark = ($urandom_range(19) != 0);
        cc   = (cfg_channels == 3'd0) ? 1 : int'(cfg_channels);
        dep  = 8'($urandom_range(1, MAX_DEPTH));
        cap  = 64'(cfg_image_bytes) * 64'(dep);
        if (kind < 65) begin
            if (cap < 2)
                len = 0;
            else if (cap > 98 && $urandom_range(7) == 0)
                len = $urandom_range(97, 32'(cap - 1));
            else
                len = $urandom_range(1, (cap - 1 < 96) ? 32'(cap - 1) : 96);
            need = (int'(len) + int'(dep) - 1) / int'(dep);
            if (len > 96)
                msg_n = $urandom_range(0, 40);
            else if ($urandom_range(5) == 0)
                msg_n = $urandom_range(0, need);
            else
                msg_n = need + $urandom_range(0, 3);
            queue_frame(len, dep, msg_n, mark, 1'b0, -1);
        end else if (kind < 75) begin
            queue_frame(32'd0, dep, $urandom_range(0, 3), mark, 1'b0, -1);
        end else if (kind < 85) begin
            len = $urandom;
            case ($urandom_range(3))
                0: dep = 8'd0;
                1: dep = 8'($urandom_range(MAX_DEPTH + 1, 255));
                2: len = 32'(cap) + $urandom_range(0, 20);
                default: len = $urandom | 32'h8000_0000;
            endcase
            queue_frame(len, dep, $urandom_range(0, 4), mark, 1'b0, -1);
        end else if (kind < 90) begin
            // header cut short by the next frame
            queue_frame($urandom, dep, 0, mark, 1'b0,
                        $urandom_range(1, HEADER_PIXELS * cc - 1));
        end else begin
            repeat ($urandom_range(1, 60)) begin
                it.data = 8'($urandom);
                it.fs   = ($urandom_range(7) == 0);
                image_feed.push_back(it);
            end
        end
    endtask

    task automatic drain();
        while (image_feed.size() != 0 || expected_words.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_settings(logic [2:0] cc, logic [CNT_W-1:0] nbytes);
        drain();
        repeat (8) @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_CHANNEL_COUNT;
        i_cfg_data <= CNT_W'(cc);
        @(negedge i_clk);
        i_cfg_idx  <= CFG_IMAGE_BYTES;
        i_cfg_data <= nbytes;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        settings_used++;
    endtask

    initial begin : stimulus
        int               base_items;
        int               base_words;
        logic [2:0]       cc_set[8];
        logic [CNT_W-1:0] nb_set[8];
        int               idle_mix[4];
        int               stall_mix[4];
        cc_set    = '{3'd1, 3'd4, 3'd0, 3'd2, 3'd3, 3'd1, 3'd4, 3'd2};
        nb_set    = '{27'd67108864, 27'd40, 27'd1, 27'd9,
                      27'd1000000, 27'd300, 27'd67108864, 27'd1};
        idle_mix  = '{0, 87, 0, 35};
        stall_mix = '{0, 0, 87, 35};

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: three channels, one image byte (capacity = depth)
        queue_frame(32'd0, 8'd1, 2, 1'b0, 1'b0, -1);      // empty message, no frame_start
        queue_frame(32'd0, 8'd0, 1, 1'b1, 1'b0, -1);      // depth zero
        queue_frame(32'd1, 8'd7, 1, 1'b1, 1'b0, -1);      // depth above six
        queue_frame(32'd5, 8'd6, 2, 1'b1, 1'b0, -1);      // five bits, partial last byte
        queue_frame(32'd6, 8'd6, 1, 1'b1, 1'b0, -1);      // length equals capacity
        queue_frame(32'd1, 8'd1, 3, 1'b1, 1'b1, -1);      // past image end, extra bytes ignored
        write_settings(3'd1, 27'd67108864);
        queue_frame(32'd10, 8'd6, 2, 1'b1, 1'b0, -1);     // full byte and last byte together
        queue_frame(32'hFFFF_FFFF, 8'd6, 1, 1'b1, 1'b0, -1);
        queue_frame(32'd16, 8'd1, 20, 1'b1, 1'b1, -1);    // 0xFF/0x00 bytes, trailing ignored
        queue_frame(32'd40, 8'd1, 10, 1'b1, 1'b0, -1);    // cut short by next frame
        queue_frame(32'd24, 8'd255, 1, 1'b1, 1'b0, -1);
        queue_frame(32'd48, 8'd6, 8, 1'b1, 1'b0, -1);

        for (int p = 0; p < 4; p++) begin
            for (int s = 0; s < 2; s++) begin
                write_settings(cc_set[2*p+s], nb_set[2*p+s]);
                feed_idle  = idle_mix[p];
                pop_stall  = stall_mix[p];
                base_items = frame_items;
                base_words = words_predicted;
                while (frame_items - base_items < 40 || words_predicted - base_words < 2) begin
                    queue_random_frame();
                    while (image_feed.size() > 64) @(negedge i_clk);
                end
            end
        end

        drain();
        repeat (10) @(negedge i_clk);
        $display("Fed %0d image bytes, checked %0d message words over %0d register settings",
                 bytes_taken, words_checked, settings_used);
        $display("and four traffic mixes; %0d mismatches.", errors);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #5000000;
        $display("FAILURE");
        $finish;
    end

endmodule
`default_nettype wire
